/* rtl/core/poly_from_roots_modular_top_defines.svh */
// Assertion macros for the poly_from_roots_modular block.
// Used by the checker; expects clk_i and rst_ni in the scope of use.
`ifndef POLY_FROM_ROOTS_MODULAR_TOP_DEFINES_SVH
`define POLY_FROM_ROOTS_MODULAR_TOP_DEFINES_SVH

// generic clocked assertion with async low reset
`define PFR_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the block clock and reset
`define PFR_ASSERT(lbl, prop, msg) `PFR_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

/* rtl/core/pfr_pkg.sv */
// Shared types and constants for the polynomial-from-roots block.
// No dependencies.
`default_nettype none
package pfr_pkg;
  localparam int CoefW       = 63;
  localparam int DegW        = 6;
  localparam int MaxRootsDef = 32;
  localparam int DataW       = 64;
  localparam int AddrW       = 4;
  localparam logic RegModulus = 1'b0;  // register index, taken from paddr[3]
  localparam logic [CoefW-1:0] ModulusReset = CoefW'(2);

  typedef struct packed {
    logic [CoefW-1:0] root;
    logic             present;
    logic             last;
  } item_t;

  typedef struct packed {
    logic             start;
    logic [CoefW-1:0] x;  // scanned operand, any value
    logic [CoefW-1:0] y;  // added operand, below the modulus
  } mul_req_t;
endpackage
`default_nettype wire

/* rtl/core/pfr_if.sv */
// Stream interfaces for root items and coefficient results.
// Depends on pfr_pkg.
`default_nettype none
interface pfr_in_if;
  import pfr_pkg::*;
  logic             valid;
  logic             ready;
  logic [CoefW-1:0] root;
  logic             root_present;
  logic             last;
  modport source (output valid, root, root_present, last, input ready);
  modport sink (input valid, root, root_present, last, output ready);
endinterface

interface pfr_out_if;
  import pfr_pkg::*;
  logic             valid;
  logic             ready;
  logic [CoefW-1:0] coefficient;
  logic [DegW-1:0]  degree;
  logic             final_coefficient;
  logic             overflow;
  modport source (output valid, coefficient, degree, final_coefficient, overflow,
                  input ready);
  modport sink (input valid, coefficient, degree, final_coefficient, overflow,
                output ready);
endinterface
`default_nettype wire

/* rtl/core/pfr_front.sv */
// Front end: accepts root items and drops empty items that are not last.
// Depends on pfr_pkg and pfr_in_if.
`default_nettype none
module pfr_front (
  pfr_in_if.sink          in_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output pfr_pkg::item_t  push_item_o
);
  import pfr_pkg::*;

  assign in_i.ready   = push_ready_i;
  // an item with no root and no last flag has no effect at all
  assign push_valid_o = in_i.valid & (in_i.root_present | in_i.last);
  assign push_item_o  = '{root: in_i.root, present: in_i.root_present, last: in_i.last};
endmodule
`default_nettype wire

/* rtl/core/pfr_queue.sv */
// Two-entry queue between front end and back end.
// Depends on pfr_pkg.
`default_nettype none
module pfr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  pfr_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output pfr_pkg::item_t pop_item_o
);
  import pfr_pkg::*;

  item_t       slot_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  fill_q;
  logic        push, pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_item_o   = slot_q[rd_ptr_q];
  assign push = push_valid_i & push_ready_o;
  assign pop  = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= push_item_i;
  end
endmodule
`default_nettype wire

/* rtl/core/pfr_mulmod.sv */
// Bit-serial modular multiplier: x * y mod n, one bit of x per cycle.
// Depends on pfr_pkg. x may be unreduced; y must be below n.
`default_nettype none
module pfr_mulmod (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pfr_pkg::mul_req_t      req_i,
  input  logic [pfr_pkg::CoefW-1:0] n_i,
  output logic                   done_o,
  output logic [pfr_pkg::CoefW-1:0] res_o
);
  import pfr_pkg::*;

  localparam int CntW = $clog2(CoefW);

  logic             busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [CoefW-1:0] x_q, y_q, acc_q;
  logic [CoefW:0]   n_ext, dbl, dbl_r, sum, sum_r;

  always_comb begin
    n_ext = {1'b0, n_i};
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= n_ext) ? dbl - n_ext : dbl;
    sum   = dbl_r + (x_q[CoefW-1] ? {1'b0, y_q} : '0);
    sum_r = (sum >= n_ext) ? sum - n_ext : sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(CoefW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      x_q   <= req_i.x;
      y_q   <= req_i.y;
    end else if (busy_q) begin
      acc_q <= sum_r[CoefW-1:0];
      x_q   <= {x_q[CoefW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;
endmodule
`default_nettype wire

/* rtl/core/pfr_back.sv */
// Back end: coefficient store, per-root update sequencer and emission.
// Depends on pfr_pkg, pfr_mulmod and pfr_out_if.
`default_nettype none
module pfr_back #(
  parameter int MaxRoots = pfr_pkg::MaxRootsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [pfr_pkg::CoefW-1:0] modulus_i,
  input  logic                      pop_valid_i,
  output logic                      pop_ready_o,
  input  pfr_pkg::item_t            pop_item_i,
  pfr_out_if.source                 out_o
);
  import pfr_pkg::*;

  localparam int CntW = $clog2(MaxRoots + 1);
  localparam int IdxW = (MaxRoots > 1) ? $clog2(MaxRoots) : 1;

  typedef enum logic [4:0] {
    S_IDLE, S_RRED, S_RRED_W, S_STEP, S_LO_RD, S_LO_MUL, S_LO_W, S_P_SEL,
    S_P_RD, S_P_MUL, S_P_W, S_WR, S_E_NEXT, S_E_RD, S_E_MUL, S_E_W, S_E_OUT
  } state_e;

  state_e           state_q;
  logic [CntW-1:0]  count_q, idx_q;
  logic             ovf_q, last_q, pfin_q;
  logic [CoefW-1:0] root_q, r_q, lo_q, p_q, cval_q, rdata_q;
  logic [CoefW-1:0] mem [MaxRoots];

  logic             ovalid_q, ofin_q, oovf_q;
  logic [CoefW-1:0] ocoef_q;
  logic [DegW-1:0]  odeg_q;

  logic [CoefW-1:0] n_eff, wdata;
  logic [CoefW:0]   diff;
  logic [IdxW-1:0]  rd_addr, idx_m1;
  logic             rd_en, mul_done, out_free, emit_fire;
  logic [CoefW-1:0] mul_res;
  mul_req_t         mul_req;

  assign n_eff    = (modulus_i < CoefW'(2)) ? CoefW'(2) : modulus_i;
  assign idx_m1   = IdxW'(idx_q - 1'b1);
  assign rd_addr  = (state_q == S_LO_RD) ? idx_m1 : IdxW'(idx_q);
  assign rd_en    = (state_q == S_LO_RD) || (state_q == S_P_RD) || (state_q == S_E_RD);
  // lo - p mod n, both below n
  assign diff     = {1'b0, lo_q} + {1'b0, n_eff} - {1'b0, p_q};
  assign wdata    = (lo_q >= p_q) ? lo_q - p_q : diff[CoefW-1:0];
  assign out_free = !ovalid_q || out_o.ready;
  assign emit_fire = (state_q == S_E_OUT) && out_free;
  assign pop_ready_o = (state_q == S_IDLE);

  always_comb begin
    mul_req.start = (state_q == S_RRED) || (state_q == S_LO_MUL) ||
                    (state_q == S_P_MUL) || (state_q == S_E_MUL);
    mul_req.x     = (state_q == S_RRED) ? root_q : rdata_q;
    mul_req.y     = (state_q == S_P_MUL) ? r_q : CoefW'(1);
  end

  pfr_mulmod u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .n_i    (n_eff),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem[rd_addr];
    if (state_q == S_WR) mem[IdxW'(idx_q)] <= wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      ovf_q    <= 1'b0;
      last_q   <= 1'b0;
      pfin_q   <= 1'b0;
      root_q   <= '0;
      r_q      <= '0;
      lo_q     <= '0;
      p_q      <= '0;
      cval_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (pop_valid_i) begin
            root_q <= pop_item_i.root;
            last_q <= pop_item_i.last;
            idx_q  <= '0;
            if (pop_item_i.present && (count_q < CntW'(MaxRoots))) begin
              state_q <= S_RRED;
            end else begin
              if (pop_item_i.present) ovf_q <= 1'b1;
              if (pop_item_i.last) state_q <= S_E_NEXT;
            end
          end
        end
        S_RRED:   state_q <= S_RRED_W;
        S_RRED_W: begin
          if (mul_done) begin
            r_q     <= mul_res;
            idx_q   <= count_q;
            state_q <= S_STEP;
          end
        end
        S_STEP: begin
          if (idx_q != '0) begin
            state_q <= S_LO_RD;
          end else begin
            lo_q    <= '0;
            state_q <= S_P_SEL;
          end
        end
        S_LO_RD:  state_q <= S_LO_MUL;
        S_LO_MUL: state_q <= S_LO_W;
        S_LO_W: begin
          if (mul_done) begin
            lo_q    <= mul_res;
            state_q <= S_P_SEL;
          end
        end
        S_P_SEL: begin
          // the implied leading 1 times r is just r
          if (idx_q == count_q) begin
            p_q     <= r_q;
            state_q <= S_WR;
          end else begin
            state_q <= S_P_RD;
          end
        end
        S_P_RD:  state_q <= S_P_MUL;
        S_P_MUL: state_q <= S_P_W;
        S_P_W: begin
          if (mul_done) begin
            p_q     <= mul_res;
            state_q <= S_WR;
          end
        end
        S_WR: begin
          if (idx_q == '0) begin
            count_q <= count_q + 1'b1;
            state_q <= last_q ? S_E_NEXT : S_IDLE;
          end else begin
            idx_q   <= idx_q - 1'b1;
            state_q <= S_STEP;
          end
        end
        S_E_NEXT: begin
          if (idx_q == count_q) begin
            cval_q  <= CoefW'(1);
            pfin_q  <= 1'b1;
            state_q <= S_E_OUT;
          end else begin
            state_q <= S_E_RD;
          end
        end
        S_E_RD:  state_q <= S_E_MUL;
        S_E_MUL: state_q <= S_E_W;
        S_E_W: begin
          if (mul_done) begin
            cval_q  <= mul_res;
            state_q <= S_E_OUT;
          end
        end
        S_E_OUT: begin
          if (out_free) begin
            if (pfin_q) begin
              // run done: back to the empty product
              count_q <= '0;
              ovf_q   <= 1'b0;
              pfin_q  <= 1'b0;
              idx_q   <= '0;
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= S_E_NEXT;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // output register, reloaded only when empty or being drained
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      ofin_q   <= 1'b0;
      oovf_q   <= 1'b0;
    end else if (emit_fire) begin
      ovalid_q <= 1'b1;
      ofin_q   <= pfin_q;
      oovf_q   <= ovf_q;
    end else if (out_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      ocoef_q <= cval_q;
      odeg_q  <= DegW'(idx_q);
    end
  end

  assign out_o.valid             = ovalid_q;
  assign out_o.coefficient       = ocoef_q;
  assign out_o.degree            = odeg_q;
  assign out_o.final_coefficient = ofin_q;
  assign out_o.overflow          = oovf_q;
endmodule
`default_nettype wire

/* rtl/core/poly_from_roots_modular_top.sv */
// Top level of the polynomial-from-roots (mod n) block with its APB register.
// Depends on pfr_pkg, pfr_if, pfr_front, pfr_queue, pfr_back.
//
// Roots arrive one item at a time; the block keeps the monic product of
// (X - root) mod n and, on an item marked last, sends every coefficient from
// degree 0 up to the leading 1 (final_coefficient set), then starts over.
// Everything runs through one bit-serial modular multiplier. A root that finds d
// roots stored holds the back end for the reduction of the root and two products
// per stored coefficient; emitting a product of d roots takes one product per
// stored coefficient plus the leading 1, and waits while the receiver stalls.
// A two-entry queue lets the input side accept up to two more items while the
// back end works.
// The modulus register sits at byte address 0 (paddr[3] low); values 0 and 1
// act as 2. Write it only while the block is idle.
`default_nettype none
module poly_from_roots_modular_top #(
  parameter int MaxRoots = pfr_pkg::MaxRootsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  pfr_in_if.sink                    in_i,
  pfr_out_if.source                 out_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pfr_pkg::AddrW-1:0] paddr,
  input  logic [pfr_pkg::DataW-1:0] pwdata,
  output logic [pfr_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import pfr_pkg::*;

  logic [CoefW-1:0] modulus_q;
  logic             push_valid, push_ready, pop_valid, pop_ready;
  item_t            push_item, pop_item;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == RegModulus) ? {1'b0, modulus_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= ModulusReset;
    end else if (psel && penable && pwrite && pready && (paddr[3] == RegModulus)) begin
      modulus_q <= pwdata[CoefW-1:0];
    end
  end

  pfr_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  pfr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  pfr_back #(.MaxRoots(MaxRoots)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .modulus_i   (modulus_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_o       (out_o)
  );
endmodule
`default_nettype wire

/* rtl/core/pfr_checker.sv */
// Port-level checker for poly_from_roots_modular_top, attached by bind.
// Depends on pfr_pkg and poly_from_roots_modular_top_defines.svh.
`default_nettype none
`include "poly_from_roots_modular_top_defines.svh"
module pfr_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [pfr_pkg::CoefW-1:0] out_coef,
  input logic                      out_final,
  input logic [pfr_pkg::DataW-1:0] prdata,
  input logic                      pready
);
  import pfr_pkg::*;

  property p_out_hold;
    out_valid && !out_ready |=> out_valid && $stable(out_coef);
  endproperty

  property p_final_one;
    out_valid && out_final |-> out_coef == CoefW'(1);
  endproperty

  property p_final_gap;
    out_valid && out_ready && out_final |=> !out_valid;
  endproperty

  property p_apb;
    pready && (prdata[DataW-1] == 1'b0);
  endproperty

  `PFR_ASSERT(a_out_hold, p_out_hold, "result dropped or changed while stalled")
  `PFR_ASSERT(a_final_one, p_final_one, "leading coefficient not one")
  `PFR_ASSERT(a_final_gap, p_final_gap, "result right after a final transfer")
  `PFR_ASSERT(a_apb, p_apb, "register read or ready wrong")
endmodule

bind poly_from_roots_modular_top pfr_checker u_pfr_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_coef  (out_o.coefficient),
  .out_final (out_o.final_coefficient),
  .prdata    (prdata),
  .pready    (pready)
);
`default_nettype wire

/* tb/sv/pfr_checker.sv */
// Checker for poly_from_roots_modular_top: watches both streams and the APB port,
// predicts the coefficient stream per root set and compares field by field.
// Depends on pfr_pkg and pfr_if.
`timescale 1ns / 100ps
module pfr_tb_checker import pfr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  pfr_in_if                   in_w,
  pfr_out_if                  out_w,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [DataW-1:0]    pwdata,
  input  logic                pready,
  output int                  fails_o,
  output int                  pending_o
);
  typedef struct packed {
    logic [CoefW-1:0] coef;
    logic [DegW-1:0]  deg;
    logic             fin;
    logic             ovf;
  } coef_t;

  coef_t            coef_q[$];
  logic [CoefW-1:0] modulus;
  logic [CoefW-1:0] poly_c[MaxRootsDef];
  int               root_cnt;
  logic             ovf_flag;

  assign pending_o = coef_q.size();

  function automatic logic [CoefW-1:0] mul_mod(logic [CoefW-1:0] a, logic [CoefW-1:0] b,
                                               logic [CoefW-1:0] n);
    logic [2*CoefW-1:0] p;
    p = a * b;
    return CoefW'(p % n);
  endfunction

  // a, b below n
  function automatic logic [CoefW-1:0] sub_mod(logic [CoefW-1:0] a, logic [CoefW-1:0] b,
                                               logic [CoefW-1:0] n);
    return (a >= b) ? a - b : n - (b - a);
  endfunction

  task automatic report(string what, logic [CoefW-1:0] exp_v, logic [CoefW-1:0] got_v);
    $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, exp_v, got_v);
    fails_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : predict
    logic [CoefW-1:0] n, r, lower;
    coef_t            e, g;
    int               d;
    if (!rst_ni) begin
      modulus  <= ModulusReset;
      root_cnt = 0;
      ovf_flag = 1'b0;
      coef_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[3] == RegModulus)
        modulus <= pwdata[CoefW-1:0];
      n = (modulus < 2) ? CoefW'(2) : modulus;
      if (in_w.valid && in_w.ready) begin
        if (in_w.root_present) begin
          if (root_cnt < MaxRootsDef) begin
            r = in_w.root % n;
            d = root_cnt;
            // multiply by (X - r), top coefficient first
            poly_c[d] = sub_mod((d == 0) ? '0 : poly_c[d-1] % n, r, n);
            for (int k = d; k > 0; k--) begin
              lower = (k == 1) ? '0 : poly_c[k-2] % n;
              poly_c[k-1] = sub_mod(lower, mul_mod(poly_c[k-1] % n, r, n), n);
            end
            root_cnt = d + 1;
          end else begin
            ovf_flag = 1'b1;
          end
        end
        if (in_w.last) begin
          for (int k = 0; k <= root_cnt; k++) begin
            e.coef = (k == root_cnt) ? CoefW'(1) : poly_c[k] % n;
            e.deg  = DegW'(k);
            e.fin  = (k == root_cnt);
            e.ovf  = ovf_flag;
            coef_q.push_back(e);
          end
          root_cnt = 0;
          ovf_flag = 1'b0;
        end
      end
      if (out_w.valid && out_w.ready) begin
        g = '{out_w.coefficient, out_w.degree, out_w.final_coefficient, out_w.overflow};
        if (coef_q.size() == 0) begin
          report("unexpected transfer, coefficient", '0, g.coef);
        end else begin
          e = coef_q.pop_front();
          if (g.coef !== e.coef) report("coefficient", e.coef, g.coef);
          if (g.deg !== e.deg) report("degree", CoefW'(e.deg), CoefW'(g.deg));
          if (g.fin !== e.fin) report("final_coefficient", CoefW'(e.fin), CoefW'(g.fin));
          if (g.ovf !== e.ovf) report("overflow", CoefW'(e.ovf), CoefW'(g.ovf));
        end
      end
    end
  end

  initial fails_o = 0;
endmodule

/* tb/sv/tb.sv */
// Testbench top for poly_from_roots_modular_top: clock, reset, root stimulus,
// output stalls and modulus writes; verdict from pfr_tb_checker's failure count.
// Depends on pfr_pkg, pfr_if, pfr_tb_checker and the block.
`timescale 1ns / 100ps
module tb;
  import pfr_pkg::*;

  localparam logic [CoefW-1:0] ModMax = {CoefW{1'b1}};

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel, penable, pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata, prdata;
  logic             pready;
  int               fails, pending;
  bit               gaps_on = 1'b1;
  bit               hold_req = 1'b0;
  int               n_items = 0;
  logic [CoefW-1:0] cur_mod = ModulusReset;

  pfr_in_if  in_bus();
  pfr_out_if out_bus();

  poly_from_roots_modular_top u_top (
    .clk_i, .rst_ni, .in_i(in_bus), .out_o(out_bus),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  pfr_tb_checker u_chk (
    .clk_i, .rst_ni, .in_w(in_bus), .out_w(out_bus),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fails_o(fails), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // receiver side: random stall bursts, plus one long hold-off on request
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (3000) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(4) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(posedge clk_i);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic send(logic [CoefW-1:0] root, logic present, logic last);
    if (gaps_on && $urandom_range(4) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_bus.valid        <= 1'b1;
    in_bus.root         <= root;
    in_bus.root_present <= present;
    in_bus.last         <= last;
    do @(posedge clk_i); while (!in_bus.ready);
    n_items++;
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_mod(logic [DataW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= '0;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    cur_mod = v[CoefW-1:0];
  endtask

  function automatic logic [DataW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [CoefW-1:0] rand_root();
    logic [CoefW-1:0] m;
    m = (cur_mod < 2) ? CoefW'(2) : cur_mod;
    // mostly reduced roots, sometimes raw ones that may lie at or above the modulus
    if ($urandom_range(9) == 0) return CoefW'(rand64());
    return CoefW'(rand64()) % m;
  endfunction

  task automatic new_modulus();
    case ($urandom_range(8))
      0: write_mod(DataW'(0));
      1: write_mod(DataW'(1));
      2: write_mod(DataW'(2));
      3: write_mod(DataW'(3));
      4: write_mod({1'b1, ModMax});
      5: write_mod(DataW'($urandom_range(65535, 2)));
      6: write_mod({2'b01, 62'(rand64())});
      default: write_mod(rand64());
    endcase
  endtask

  initial begin
    int set_len, big_sets;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    in_bus.valid <= 1'b0; in_bus.root <= '0; in_bus.root_present <= 1'b0;
    in_bus.last <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset modulus, empty sets, extremes, unreduced roots
    send('0, 1'b0, 1'b1);
    send('0, 1'b0, 1'b0);
    send(CoefW'(1), 1'b1, 1'b1);
    drain();
    write_mod(DataW'(0));
    send(CoefW'(1), 1'b1, 1'b0);
    send(CoefW'(1), 1'b1, 1'b1);
    drain();
    write_mod(DataW'(1));
    send(CoefW'(3), 1'b1, 1'b1);
    drain();
    write_mod(DataW'(97));
    send('0, 1'b1, 1'b0);
    send(CoefW'(96), 1'b1, 1'b0);
    send(CoefW'(200), 1'b1, 1'b0);
    send('0, 1'b0, 1'b1);
    drain();
    write_mod({1'b1, ModMax});
    send(ModMax - 1, 1'b1, 1'b0);
    send(ModMax - 1, 1'b1, 1'b1);
    send(ModMax, 1'b1, 1'b1);
    drain();
    // modulus changed while a product is stored
    write_mod(DataW'(1000003));
    send(CoefW'(5), 1'b1, 1'b0);
    send(CoefW'(999999), 1'b1, 1'b0);
    in_bus.valid <= 1'b0;
    repeat (5000) @(posedge clk_i);
    write_mod(DataW'(13));
    send('0, 1'b0, 1'b1);
    drain();

    // random root sets; two hold more items than the capacity
    big_sets = 0;
    while (n_items < 350) begin
      if ($urandom_range(5) == 0) begin
        drain();
        new_modulus();
      end
      if (n_items > 300) gaps_on = 1'b0;
      if (big_sets < 2 && n_items > 60 + big_sets * 120) begin
        set_len = $urandom_range(MaxRootsDef + 3, MaxRootsDef + 1);
        big_sets++;
        hold_req = (big_sets == 1);
      end else begin
        set_len = $urandom_range(6);
      end
      for (int i = 0; i < set_len; i++)
        send(rand_root(), $urandom_range(6) != 0, 1'b0);
      send(rand_root(), 1'($urandom_range(1)), 1'b1);
    end
    drain();

    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
